// File: src/scma_pkg.sv
`default_nettype none

package scma_pkg;

    // six coordinate channels of 16 bits each
    localparam int CHANNELS = 6;
    localparam int COORD_W  = 16;

    // one input beat: the new sample
    typedef struct packed {
        logic signed [COORD_W-1:0] centroid_x_in;
        logic signed [COORD_W-1:0] centroid_y_in;
        logic signed [COORD_W-1:0] pivot_x_in;
        logic signed [COORD_W-1:0] pivot_y_in;
        logic signed [COORD_W-1:0] guide_x_in;
        logic signed [COORD_W-1:0] guide_y_in;
    } sample_t;

    // one result beat: the window means
    typedef struct packed {
        logic signed [COORD_W-1:0] centroid_x_avg;
        logic signed [COORD_W-1:0] centroid_y_avg;
        logic signed [COORD_W-1:0] pivot_x_avg;
        logic signed [COORD_W-1:0] pivot_y_avg;
        logic signed [COORD_W-1:0] guide_x_avg;
        logic signed [COORD_W-1:0] guide_y_avg;
    } avg_t;

    // channel view of either struct, same bit order
    typedef logic [CHANNELS-1:0][COORD_W-1:0] coord_vec_t;

endpackage

`default_nettype wire

// File: src/scma_div.sv
`default_nettype none

module scma_div
    import scma_pkg::*;
#(
    parameter int DIVIDEND_W = 19,
    parameter int DIVISOR_W  = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [DIVIDEND_W-1:0] dividend,
    input  logic        [DIVISOR_W-1:0]  divisor,
    output logic                         done,
    output logic        [COORD_W-1:0]    quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  neg_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  div_reg;

    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W-1:0]  rem_sub;
    logic                  fits;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVIDEND_W-1:0] magnitude;
    logic [COORD_W-1:0]    quo_low;

    // restoring step: bring down one dividend bit and try the subtract
    // when the subtract fits the difference is below the divisor, so the low bits hold it
    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign rem_sub   = rem_shift[DIVISOR_W-1:0] - div_reg;
    assign fits      = (rem_shift >= {1'b0, div_reg});
    assign rem_next  = fits ? rem_sub : rem_shift[DIVISOR_W-1:0];

    // work on the magnitude, restore the sign at the end
    assign magnitude = dividend[DIVIDEND_W-1] ? (DIVIDEND_W'(0) - dividend) : dividend;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIVIDEND_W);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[DIVIDEND_W-1];
            quo_reg <= magnitude;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    // mean always fits in 16 bits, so the low bits carry it
    assign quo_low  = quo_reg[COORD_W-1:0];
    assign quotient = neg_reg ? (COORD_W'(0) - quo_low) : quo_low;
    assign done     = done_reg;

endmodule

`default_nettype wire

// File: src/six_channel_moving_average.sv
`default_nettype none

// channel  | ports                          | beat
// ---------+--------------------------------+-----------------------------
// input    | s_valid, s_ready, s_sample     | sample_t: six new coordinates
// result   | m_valid, m_ready, m_result     | avg_t: six window means
//
// One sample at a time: accept, ring update, divider load, then the six
// parallel bit-serial dividers; the next sample is accepted only after the
// previous result has been loaded into the output register.
// Running sums subtract the entry being overwritten, read in the cycle before the overwrite.
// Reset clears pointer, fill count and sums; the ring itself is not cleared.
// A stalled result sits in the output register; the next sample is accepted
// meanwhile and its result waits until the register is free.

module six_channel_moving_average
    import scma_pkg::*;
#(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  sample_t s_sample,
    output logic    m_valid,
    input  logic    m_ready,
    output avg_t    m_result
);

    localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = COORD_W + $clog2(WINDOW_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_START,
        ST_DIVIDE,
        ST_DELIVER
    } state_t;

    state_t                   state_reg;
    logic                     m_valid_reg;
    avg_t                     m_result_reg;

    sample_t                  ring_mem [WINDOW_DEPTH];
    sample_t                  in_reg;
    sample_t                  old_reg;
    logic [PTR_W-1:0]         wptr_reg;
    logic [PTR_W-1:0]         wptr_next;
    logic [CNT_W-1:0]         fill_reg;
    logic [CNT_W-1:0]         fill_next;
    logic                     full;
    logic signed [SUM_W-1:0]  sum_reg  [CHANNELS];
    logic signed [SUM_W-1:0]  sum_next [CHANNELS];

    coord_vec_t               in_vec;
    coord_vec_t               old_vec;
    coord_vec_t               avg_vec;
    logic [CHANNELS-1:0]      lane_done;
    logic                     in_beat;
    logic                     out_free;
    logic                     result_load;

    assign in_beat  = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

    // a finished result moves into the output register this cycle
    assign result_load = out_free
                       && (((state_reg == ST_DIVIDE) && (&lane_done))
                           || (state_reg == ST_DELIVER));

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready && !result_load) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    state_reg <= ST_START;
                end
                ST_START: begin
                    state_reg <= ST_DIVIDE;
                end
                ST_DIVIDE: begin
                    if (&lane_done) begin
                        if (out_free) begin
                            m_valid_reg  <= 1'b1;
                            m_result_reg <= avg_t'(avg_vec);
                            state_reg    <= ST_IDLE;
                        end else begin
                            state_reg <= ST_DELIVER;
                        end
                    end
                end
                ST_DELIVER: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_result_reg <= avg_t'(avg_vec);
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // sample ring: read the slot about to be overwritten, write it next cycle
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            in_reg  <= s_sample;
            old_reg <= ring_mem[wptr_reg];
        end
        if (state_reg == ST_UPDATE) begin
            ring_mem[wptr_reg] <= in_reg;
        end
    end

    // pointer and fill count
    assign full      = (fill_reg == CNT_W'(WINDOW_DEPTH));
    assign wptr_next = (wptr_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
    assign fill_next = full ? fill_reg : fill_reg + 1'b1;

    // running sums: add the new sample, drop the oldest once the window is full
    assign in_vec  = coord_vec_t'(in_reg);
    assign old_vec = coord_vec_t'(old_reg);

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            sum_next[c] = sum_reg[c] + SUM_W'($signed(in_vec[c]))
                        - (full ? SUM_W'($signed(old_vec[c])) : SUM_W'(0));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            fill_reg <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                sum_reg[c] <= '0;
            end
        end else if (state_reg == ST_UPDATE) begin
            wptr_reg <= wptr_next;
            fill_reg <= fill_next;
            for (int c = 0; c < CHANNELS; c++) begin
                sum_reg[c] <= sum_next[c];
            end
        end
    end

    // one serial divider per channel, run in lockstep
    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        scma_div #(
            .DIVIDEND_W (SUM_W),
            .DIVISOR_W  (CNT_W)
        ) u_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (state_reg == ST_START),
            .dividend (sum_reg[g]),
            .divisor  (fill_reg),
            .done     (lane_done[g]),
            .quotient (avg_vec[g])
        );
    end

endmodule

`default_nettype wire

// File: src/scma_props.sv
`default_nettype none

module scma_props
    import scma_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire avg_t m_result
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result))
        else $error("result beat changed while stalled");

    // one sample in flight: input closes right after a beat
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input open again right after a beat");

    // a result does not rise while its sample is in the ring update and divider load states
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid) ##1 !$rose(m_valid))
        else $error("result appeared too early");

    // after reset: no result pending, input open
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("bad state after reset");

endmodule

bind six_channel_moving_average scma_props u_scma_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_result (m_result)
);

`default_nettype wire

// File: test/six_channel_moving_average_test.sv
`timescale 1ns / 100ps

module six_channel_moving_average_test;
    import scma_pkg::*;

    localparam int DEPTH       = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 3000;
    localparam int TAIL_CYCLES = 60;
    localparam int PHASE_BEATS = 420;
    localparam int PRINT_CAP   = 40;

    logic    aclk;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    sample_t s_sample;
    logic    m_valid;
    logic    m_ready;
    avg_t    m_result;

    // window model
    coord_vec_t window_ring [DEPTH];
    int         wr_ptr;
    int         fill_level;
    avg_t       expected_q [$];

    int error_count;
    int sender_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int hold_served;
    int hold_left;
    int idle_cycles;

    string avg_field_names [CHANNELS] = '{"guide_y_avg", "guide_x_avg", "pivot_y_avg",
                                          "pivot_x_avg", "centroid_y_avg", "centroid_x_avg"};

    six_channel_moving_average #(
        .WINDOW_DEPTH(DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_sample(s_sample),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_result(m_result)
    );

    always #6 aclk = ~aclk;

    // store the sample, then average each channel over the filled window
    function automatic avg_t predict_average(input sample_t smp);
        coord_vec_t means;
        int sum;
        window_ring[wr_ptr] = smp;
        wr_ptr = (wr_ptr == DEPTH - 1) ? 0 : wr_ptr + 1;
        if (fill_level < DEPTH) fill_level++;
        for (int c = 0; c < CHANNELS; c++) begin
            sum = 0;
            for (int i = 0; i < fill_level; i++) sum += $signed(window_ring[i][c]);
            // int division truncates toward zero
            means[c] = 16'(sum / fill_level);
        end
        return avg_t'(means);
    endfunction

    // mix of full-range, extreme and near-zero coordinates
    function automatic sample_t random_sample();
        coord_vec_t v;
        int pick;
        for (int c = 0; c < CHANNELS; c++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)      v[c] = 16'($urandom_range(0, 65535));
            else if (pick < 65) v[c] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            else if (pick < 85) v[c] = 16'($signed($urandom_range(0, 8)) - 4);
            else                v[c] = $urandom_range(0, 1) ? 16'(16'h7fff - $urandom_range(0, 7))
                                                            : 16'(16'h8000 + $urandom_range(0, 7));
        end
        return sample_t'(v);
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (error_count < PRINT_CAP)
            $display("%0t ns: %s got %h want %h", $time, what, got, want);
        error_count++;
    endtask

    // offer one beat after an optional idle gap, record its averages on acceptance
    task automatic send_sample(input sample_t smp);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_q.push_back(predict_average(smp));
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    // receiver: random stalls plus long hold-offs on request
    always @(posedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge aclk) begin : result_check
        coord_vec_t got_v;
        coord_vec_t want_v;
        if (aresetn && m_valid && m_ready) begin
            got_v = m_result;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result beat", got_v[CHANNELS-1], 16'h0);
            end else begin
                want_v = expected_q.pop_front();
                for (int c = 0; c < CHANNELS; c++)
                    if (got_v[c] !== want_v[c])
                        report_mismatch(avg_field_names[c], got_v[c], want_v[c]);
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // corners: partly filled window after reset, extremes, wrap of a full window
    task automatic test_directed();
        sample_t corners [10];
        corners = '{
            '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff},
            '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000},
            '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000},
            '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff},
            '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff},
            '{16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001},
            '{16'hffff, 16'h0001, 16'hfffe, 16'h0002, 16'hfffd, 16'h0003},
            '{16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa},
            '{16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555}
        };
        sender_idle_pct = 0;
        foreach (corners[i]) send_sample(corners[i]);
        // full window of the most negative value, then a few of the most positive
        repeat (DEPTH) send_sample(corners[2]);
        repeat (3) send_sample(corners[1]);
    endtask

    // random beats under each idling mix
    task automatic test_random_phases();
        int sender_mix [4] = '{0, 54, 0, 29};
        int recv_mix   [4] = '{0, 0, 54, 29};
        for (int p = 0; p < 4; p++) begin
            sender_idle_pct = sender_mix[p];
            recv_stall_pct <= recv_mix[p];
            repeat (PHASE_BEATS) send_sample(random_sample());
        end
        recv_stall_pct <= 0;
    endtask

    // receiver holds off while the sender keeps offering, input must stall
    task automatic test_backpressure();
        sender_idle_pct = 0;
        hold_requests <= hold_requests + 1;
        repeat (24) send_sample(random_sample());
    endtask

    // sender waits for every result, then resumes
    task automatic test_drain_pause();
        sender_idle_pct = 10;
        recv_stall_pct <= 20;
        repeat (30) send_sample(random_sample());
        s_valid <= 1'b0;
        wait_drained();
        @(posedge aclk);
        repeat (30) send_sample(random_sample());
    endtask

    initial begin
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_sample       = '0;
        m_ready        = 1'b0;
        wr_ptr         = 0;
        fill_level     = 0;
        error_count    = 0;
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests  = 0;
        hold_served    = 0;
        hold_left      = 0;
        idle_cycles    = 0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_phases();
        test_backpressure();
        test_drain_pause();

        s_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_q.size() != 0)
            report_mismatch("expected beats left over", 16'(expected_q.size()), 16'h0);

        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
